FILE: design/bottleneck_assignment_matcher_assert.svh
// assertion macros shared by the matcher modules
// no dependencies; included inside module bodies
`ifndef BOTTLENECK_ASSIGNMENT_MATCHER_ASSERT_SVH
`define BOTTLENECK_ASSIGNMENT_MATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bam check failed");

// next-cycle implication, checked outside reset
`define BAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bam check failed");

`endif

FILE: design/bam_pkg.sv
// shared constants and types of the bottleneck assignment matcher
// no dependencies
`default_nettype none
package bam_pkg;
  localparam int MAX_SIZE = 64;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int N_W      = IDX_W + 1;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DATA_W   = 32;
  localparam int THR_W    = DATA_W + 1;
  localparam int CFG_W    = 7;

  // status from the matching engine to the search control
  typedef struct packed {
    logic done;
    logic feasible;
  } match_status_t;
endpackage
`default_nettype wire

FILE: design/bam_weight_ram.sv
// weight matrix storage: one write port, one registered read port
// no dependencies
`default_nettype none
module bam_weight_ram #(
  parameter int AddrW = 12,
  parameter int DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [(1 << AddrW)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/bam_matcher.sv
// augmenting-path matching engine: tests one threshold per start pulse
// depends on bam_pkg and the assertion header
`default_nettype none
module bam_matcher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bam_pkg::N_W-1:0]     n_i,
  input  wire logic signed [bam_pkg::THR_W-1:0] thr_i,
  output logic      [bam_pkg::ADDR_W-1:0]  rd_addr_o,
  input  wire logic [bam_pkg::DATA_W-1:0]  rd_data_i,
  output bam_pkg::match_status_t           status_o
);
  import bam_pkg::*;
  `include "bottleneck_assignment_matcher_assert.svh"

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_ROOT   = 5'b00010,
    M_STEP   = 5'b00100,
    M_CHECK  = 5'b01000,
    M_UNWIND = 5'b10000
  } mstate_e;

  mstate_e state_q, state_d;
  logic [N_W-1:0]   depth_q, depth_d;
  logic [N_W-1:0]   root_q, root_d;
  logic [IDX_W-1:0] stk_row_q [MAX_SIZE];
  logic [N_W-1:0]   stk_col_q [MAX_SIZE];
  logic [IDX_W-1:0] partner_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] pvalid_q, visited_q;
  logic [IDX_W-1:0] cur_col_q;
  // top of stack lives in registers, the array holds the entries under it
  logic [IDX_W-1:0] top_row_q;
  logic [N_W-1:0]   top_col_q;
  logic [IDX_W-1:0] under_row_q;
  logic [N_W-1:0]   under_col_q;
  logic [IDX_W-1:0] under_idx;
  logic [IDX_W-1:0] mate_q;
  logic             below;
  logic             push;
  logic             done_q, feas_q;

  assign below     = $signed({rd_data_i[DATA_W-1], rd_data_i}) < thr_i;
  assign push      = !below && pvalid_q[cur_col_q] && !visited_q[mate_q];
  assign under_idx = depth_d[IDX_W-1:0] - IDX_W'(2);
  assign rd_addr_o = {top_row_q, top_col_q[IDX_W-1:0]};
  assign status_o  = '{done: done_q, feasible: feas_q};

  // sequencer next state
  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    root_d  = root_q;
    unique case (state_q)
      M_IDLE:  if (start_i) begin
        root_d  = '0;
        state_d = M_ROOT;
      end
      M_ROOT: begin
        depth_d = N_W'(1);
        state_d = M_STEP;
      end
      M_STEP: begin
        if (depth_q == '0) begin
          state_d = M_IDLE;
        end else if (top_col_q >= n_i) begin
          depth_d = depth_q - N_W'(1);
        end else begin
          state_d = M_CHECK;
        end
      end
      M_CHECK: begin
        state_d = M_STEP;
        if (!below) begin
          if (!pvalid_q[cur_col_q]) begin
            state_d = M_UNWIND;
          end else if (!visited_q[mate_q]) begin
            depth_d = depth_q + N_W'(1);
          end
        end
      end
      M_UNWIND: begin
        if (depth_q == '0) begin
          root_d  = root_q + N_W'(1);
          state_d = (root_q + N_W'(1) == n_i) ? M_IDLE : M_ROOT;
        end else begin
          depth_d = depth_q - N_W'(1);
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= M_IDLE;
      depth_q   <= '0;
      root_q    <= '0;
      pvalid_q  <= '0;
      visited_q <= '0;
      done_q    <= 1'b0;
      feas_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      root_q  <= root_d;
      done_q  <= 1'b0;
      if (state_q == M_IDLE && start_i) begin
        pvalid_q <= '0;
      end
      // new root: only the root row is visited
      if (state_q == M_ROOT) begin
        visited_q <= MAX_SIZE'(1) << root_q[IDX_W-1:0];
      end
      if (state_q == M_CHECK && push) begin
        visited_q[mate_q] <= 1'b1;
      end
      if (state_q == M_UNWIND && depth_q != '0) begin
        pvalid_q[top_col_q[IDX_W-1:0] - IDX_W'(1)] <= 1'b1;
      end
      // failed root ends the test as infeasible
      if (state_q == M_STEP && depth_q == '0) begin
        done_q <= 1'b1;
        feas_q <= 1'b0;
      end
      if (state_q == M_UNWIND && depth_q == '0 && root_q + N_W'(1) == n_i) begin
        done_q <= 1'b1;
        feas_q <= 1'b1;
      end
    end
  end

  // stack and partner storage
  always_ff @(posedge clk_i) begin
    // entry under the next top, registered ahead of any pop
    under_row_q <= stk_row_q[under_idx];
    under_col_q <= stk_col_q[under_idx];
    unique case (state_q)
      M_ROOT: begin
        top_row_q <= root_q[IDX_W-1:0];
        top_col_q <= '0;
      end
      M_STEP: if (depth_q != '0) begin
        if (top_col_q < n_i) begin
          top_col_q <= top_col_q + N_W'(1);
          cur_col_q <= top_col_q[IDX_W-1:0];
          mate_q    <= partner_q[top_col_q[IDX_W-1:0]];
        end else if (depth_q > N_W'(1)) begin
          top_row_q <= under_row_q;
          top_col_q <= under_col_q;
        end
      end
      M_CHECK: if (push) begin
        stk_row_q[depth_q[IDX_W-1:0] - IDX_W'(1)] <= top_row_q;
        stk_col_q[depth_q[IDX_W-1:0] - IDX_W'(1)] <= top_col_q;
        top_row_q <= mate_q;
        top_col_q <= '0;
      end
      M_UNWIND: if (depth_q != '0) begin
        partner_q[top_col_q[IDX_W-1:0] - IDX_W'(1)] <= top_row_q;
        if (depth_q > N_W'(1)) begin
          top_row_q <= under_row_q;
          top_col_q <= under_col_q;
        end
      end
      default: ;
    endcase
  end

  `BAM_ASSERT_NOW(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= n_i)
  `BAM_ASSERT_NOW(a_check_nonempty, clk_i, rst_ni, state_q == M_CHECK, depth_q != '0)
  `BAM_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_q, state_q == M_IDLE)
endmodule
`default_nettype wire

FILE: design/bottleneck_assignment_matcher.sv
// channel    | signals                               | direction
// weight     | weight_valid_i weight_stall_o weight_i | in
// result     | result_valid_o result_stall_i best_threshold_o | out
// config     | cfg_we_i cfg_wdata_i                   | in
// Matrix entries load one per cycle while weight_stall_o is low, through a single write
// port of the weight memory. After the last entry the binary search runs about 33
// thresholds; each is tested by the single matching engine, which reads the matrix
// through the one-read weight memory. No item is taken during the search.
// Reset is asynchronous, active low; no clearing pass is needed. A stalled result holds.
// depends on bam_pkg, bam_weight_ram, bam_matcher and the assertion header
`default_nettype none
module bottleneck_assignment_matcher (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bam_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                         weight_valid_i,
  output logic                              weight_stall_o,
  input  wire logic signed [bam_pkg::DATA_W-1:0] weight_i,
  output logic                              result_valid_o,
  input  wire logic                         result_stall_i,
  output logic signed [bam_pkg::DATA_W-1:0] best_threshold_o
);
  import bam_pkg::*;
  `include "bottleneck_assignment_matcher_assert.svh"

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_WAIT   = 4'b0100,
    S_OUT    = 4'b1000
  } sstate_e;

  sstate_e state_q;
  logic [CFG_W-1:0] size_q;
  logic [N_W-1:0]   n;
  logic [N_W-1:0]   row_q, col_q;
  logic signed [DATA_W-1:0] min_q, max_q, min_new, max_new;
  logic signed [THR_W-1:0]  lo_q, hi_q, mid_q, mid;
  logic signed [THR_W:0]    sum;
  logic             accept, last;
  logic             start_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  match_status_t    status;

  // clamp the configured size into the supported range
  always_comb begin
    if (size_q == '0) n = N_W'(1);
    else if (size_q > CFG_W'(MAX_SIZE)) n = N_W'(MAX_SIZE);
    else n = N_W'(size_q);
  end

  assign accept  = weight_valid_i && !weight_stall_o;
  assign last    = (row_q + N_W'(1) == n) && (col_q + N_W'(1) == n);
  assign min_new = (weight_i < min_q) ? weight_i : min_q;
  assign max_new = (weight_i > max_q) ? weight_i : max_q;
  // midpoint truncated toward zero
  assign sum = {lo_q[THR_W-1], lo_q} + {hi_q[THR_W-1], hi_q};
  assign mid = THR_W'((sum + (THR_W+1)'(sum[THR_W])) >>> 1);

  // a size write takes the cycle, the waiting item follows it
  assign weight_stall_o   = (state_q != S_LOAD) || cfg_we_i;
  assign result_valid_o   = state_q == S_OUT;
  assign best_threshold_o = hi_q[DATA_W-1:0];

  bam_weight_ram #(.AddrW(ADDR_W), .DataW(DATA_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i ({row_q[IDX_W-1:0], col_q[IDX_W-1:0]}),
    .wdata_i (weight_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bam_matcher u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .n_i       (n),
    .thr_i     (mid_q),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .status_o  (status)
  );

  // load, search control and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      size_q  <= CFG_W'(4);
      row_q   <= '0;
      col_q   <= '0;
      min_q   <= {1'b0, {(DATA_W-1){1'b1}}};
      max_q   <= {1'b1, {(DATA_W-1){1'b0}}};
      lo_q    <= '0;
      hi_q    <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        row_q  <= '0;
        col_q  <= '0;
        min_q  <= {1'b0, {(DATA_W-1){1'b1}}};
        max_q  <= {1'b1, {(DATA_W-1){1'b0}}};
      end
      unique case (state_q)
        S_LOAD: if (accept) begin
          if (last) begin
            row_q   <= '0;
            col_q   <= '0;
            min_q   <= {1'b0, {(DATA_W-1){1'b1}}};
            max_q   <= {1'b1, {(DATA_W-1){1'b0}}};
            lo_q    <= THR_W'(min_new);
            hi_q    <= THR_W'(max_new);
            state_q <= S_SEARCH;
          end else begin
            min_q <= min_new;
            max_q <= max_new;
            if (col_q + N_W'(1) == n) begin
              col_q <= '0;
              row_q <= row_q + N_W'(1);
            end else begin
              col_q <= col_q + N_W'(1);
            end
          end
        end
        S_SEARCH: begin
          if (lo_q <= hi_q) begin
            mid_q   <= mid;
            start_q <= 1'b1;
            state_q <= S_WAIT;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_WAIT: if (status.done) begin
          if (status.feasible) lo_q <= mid_q + THR_W'(1);
          else hi_q <= mid_q - THR_W'(1);
          state_q <= S_SEARCH;
        end
        S_OUT: if (!result_stall_i) begin
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `BAM_ASSERT_NOW(a_load_pos, clk_i, rst_ni, state_q == S_LOAD, row_q < n && col_q < n)
  `BAM_ASSERT_NEXT(a_start_waits, clk_i, rst_ni, start_q, state_q == S_WAIT)
  `BAM_ASSERT_NOW(a_done_in_wait, clk_i, rst_ni, status.done, state_q == S_WAIT)
endmodule
`default_nettype wire
